@@ hw/rtl/lpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Lagrange predictor coefficient block.
// Used by every RTL file of the block; depends on nothing else.
package lpc_pkg;

   // Number of history points and field widths.
   localparam int ORDER      = 4;
   localparam int TIME_W     = 64;
   localparam int TOL_W      = 32;
   localparam int COEF_W     = 64;
   localparam int IDX_W      = 2;
   localparam int HIDX_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int FILL_W     = $clog2(ORDER + 1);

   // Wide product arithmetic: 32-bit limbs, enough for 2^32 times ORDER-1 time differences.
   localparam int LIMB_W     = 32;
   localparam int PROD_LIMBS = 2 * (ORDER - 1) + 1;
   localparam int PROD_W     = PROD_LIMBS * LIMB_W;
   localparam int LCNT_W     = $clog2(PROD_LIMBS);
   localparam int QCNT_W     = $clog2(COEF_W);

   // Configuration port.
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;
   localparam logic CSR_IDX_TOL = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_ADDR,
      ST_CHK_CMP,
      ST_DECIDE,
      ST_COEF_INIT,
      ST_RD,
      ST_DIFF,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT,
      ST_OUT_INV,
      ST_APPEND
   } lpc_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_PASS0,
      MUL_SKEW,
      MUL_PASS1
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_STEP,
      DIV_FIX
   } div_state_type;

   // Result of one quotient: value and clamp flag.
   typedef struct packed {
      logic              sat;
      logic [COEF_W-1:0] coef;
   } div_res_type;

   // Logical history slot to physical slot of the circular buffer.
   function automatic logic [HIDX_W-1:0] lpc_wrap(input logic [HIDX_W-1:0] base,
                                                  input logic [HIDX_W-1:0] ofs);
      logic [HIDX_W:0] s;
      s = {1'b0, base} + {1'b0, ofs};
      if (s >= (HIDX_W + 1)'(ORDER)) begin
         s = s - (HIDX_W + 1)'(ORDER);
      end
      return s[HIDX_W-1:0];
   endfunction

endpackage

@@ hw/rtl/lpc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample times and coefficient results.
// Depends on lpc_pkg for field widths.
interface lpc_req_if import lpc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink (input valid, input sample_time, output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         coeff_index;
   logic signed [COEF_W-1:0] coefficient;
   logic                     coeffs_valid;
   logic                     history_reset;
   logic                     saturated;
   logic                     last_result;

   modport source (output valid, output coeff_index, output coefficient,
                   output coeffs_valid, output history_reset, output saturated,
                   output last_result, input ready);
   modport sink (input valid, input coeff_index, input coefficient,
                 input coeffs_valid, input history_reset, input saturated,
                 input last_result, output ready);
endinterface

@@ hw/rtl/lpc_mul.sv @@
`timescale 1ns / 1ps
// Limb-serial multiplier: wide product register times a 64-bit factor.
// One 32x32 multiplier, two passes over the limbs. Depends on lpc_pkg.
module lpc_mul import lpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] opa,
   input  logic [63:0]       opb,
   output logic              done,
   output logic [PROD_W-1:0] result
);

   mul_state_type     state_ff, state_in;
   logic [PROD_W-1:0] xs_ff, acc_ff;
   logic [LIMB_W-1:0] carry_ff;
   logic [63:0]       vb_ff;
   logic [LCNT_W-1:0] cnt_ff;
   logic              done_ff, done_in;
   logic [LIMB_W-1:0] mult;
   logic [63:0]       cur;

   // The single multiply-accumulate: low limb of the accumulator plus one partial product.
   assign mult = (state_ff == MUL_PASS1) ? vb_ff[63:32] : vb_ff[31:0];
   assign cur  = 64'(acc_ff[LIMB_W-1:0]) + 64'(xs_ff[LIMB_W-1:0]) * 64'(mult)
               + 64'(carry_ff);

   // Sequencer: pass for the low factor half, one skew rotate, pass for the high half.
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               state_in = MUL_PASS0;
            end
         end
         MUL_PASS0: begin
            if (cnt_ff == LCNT_W'(PROD_LIMBS - 1)) begin
               state_in = MUL_SKEW;
            end
         end
         MUL_SKEW: begin
            state_in = MUL_PASS1;
         end
         MUL_PASS1: begin
            if (cnt_ff == LCNT_W'(PROD_LIMBS - 2)) begin
               state_in = MUL_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Rotating operand and accumulator registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               xs_ff    <= opa;
               vb_ff    <= opb;
               acc_ff   <= '0;
               carry_ff <= '0;
               cnt_ff   <= '0;
            end
         end
         MUL_SKEW: begin
            acc_ff   <= {acc_ff[LIMB_W-1:0], acc_ff[PROD_W-1:LIMB_W]};
            carry_ff <= '0;
            cnt_ff   <= '0;
         end
         default: begin
            acc_ff   <= {cur[LIMB_W-1:0], acc_ff[PROD_W-1:LIMB_W]};
            xs_ff    <= {xs_ff[LIMB_W-1:0], xs_ff[PROD_W-1:LIMB_W]};
            carry_ff <= cur[63:32];
            cnt_ff   <= cnt_ff + 1'b1;
         end
      endcase
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

@@ hw/rtl/lpc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider giving a 64-bit quotient with sign and Q32.32 clamping.
// One wide compare-subtract per cycle. Depends on lpc_pkg.
module lpc_div import lpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] num,
   input  logic [PROD_W-1:0] den,
   input  logic              neg,
   output logic              done,
   output div_res_type       res
);

   div_state_type     state_ff, state_in;
   logic [PROD_W-1:0] num_ff, den_ff;
   logic [PROD_W:0]   rem_ff, trial;
   logic [COEF_W-1:0] q_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              neg_ff;
   logic              done_ff, done_in;
   div_res_type       res_ff;
   logic              big;
   logic              fits;

   // Quotient reaches 2^64 exactly when the numerator's upper part is not below the divisor.
   assign big   = (num_ff[PROD_W-1:COEF_W] >= den_ff);
   assign trial = {rem_ff[PROD_W-1:0], num_ff[COEF_W-1]};
   assign fits  = neg_ff ? (q_ff <= {1'b1, {(COEF_W-1){1'b0}}}) : !q_ff[COEF_W-1];

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_CHECK;
            end
         end
         DIV_CHECK: begin
            if (den_ff == '0 || big) begin
               state_in = DIV_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = DIV_STEP;
            end
         end
         DIV_STEP: begin
            if (cnt_ff == QCNT_W'(COEF_W - 1)) begin
               state_in = DIV_FIX;
            end
         end
         DIV_FIX: begin
            state_in = DIV_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath: load, early clamp, one quotient bit per cycle, then sign and range fix.
   always_ff @(posedge clock) begin
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_ff <= num;
               den_ff <= den;
               neg_ff <= neg;
            end
         end
         DIV_CHECK: begin
            rem_ff <= {1'b0, {COEF_W{1'b0}}, num_ff[PROD_W-1:COEF_W]};
            q_ff   <= '0;
            cnt_ff <= '0;
            if (den_ff == '0) begin
               res_ff.coef <= '0;
               res_ff.sat  <= 1'b1;
            end else begin
               res_ff.coef <= neg_ff ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}};
               res_ff.sat  <= 1'b1;
            end
         end
         DIV_STEP: begin
            num_ff <= {num_ff[PROD_W-1:COEF_W], num_ff[COEF_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= trial - {1'b0, den_ff};
               q_ff   <= {q_ff[COEF_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff   <= {q_ff[COEF_W-2:0], 1'b0};
            end
         end
         default: begin
            if (!fits) begin
               res_ff.coef <= neg_ff ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}};
               res_ff.sat  <= 1'b1;
            end else begin
               res_ff.coef <= neg_ff ? (~q_ff + 1'b1) : q_ff;
               res_ff.sat  <= 1'b0;
            end
         end
      endcase
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

@@ hw/rtl/lagrange_predictor_coefficients.sv @@
`timescale 1ns / 1ps
// Lagrange predictor coefficients: time history, sequencer and APB register.
// Depends on lpc_pkg, lpc_if, lpc_mul and lpc_div.
//
// Usage:
// - req_chan carries one sample time (unsigned Q32.32) per beat. The block takes
//   one beat at a time and drops ready until every result of that beat is taken.
// - rsp_chan returns ORDER coefficient beats (index 0 up, last_result on the final
//   one) when the history held ORDER times, else one beat with coeffs_valid low.
// - The APB port holds equal_tolerance at byte address 0; write it only while idle.
// The held times are checked against the tolerance in turn until one matches. With
// a full history, each coefficient takes three factor pairs, each two limb-serial
// multiplies on the one shared 32x32 multiplier, then a bit-serial restoring divide.
// Reset clears the fill count, the ring pointer, the tolerance and the sequencer;
// the history slots themselves are not cleared. A stalled receiver simply holds
// the current result beat stable and the sequencer waits.
module lagrange_predictor_coefficients import lpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lpc_req_if.sink           req_chan,
   lpc_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   lpc_state_type     state_ff, state_in;
   logic [TOL_W-1:0]  tol_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [HIDX_W-1:0] base_ff;
   logic [TIME_W-1:0] t_ff;
   logic              rst_flag_ff;
   logic [HIDX_W-1:0] i_ff, j_ff, m_ff;
   logic              neg_ff;
   logic [TIME_W-1:0] diffd_ff;
   logic [PROD_W-1:0] num_ff, den_ff;
   div_res_type       coef_ff;

   // History ring, two registered read ports.
   logic [TIME_W-1:0] hist_mem [ORDER];
   logic [TIME_W-1:0] rda_ff, rdb_ff;
   logic [HIDX_W-1:0] addr_a, addr_b, waddr;
   logic              wen;

   logic [TIME_W-1:0] diff_t, diff_h;
   logic              sign_t, sign_h;
   logic              match;
   logic              scan_end;
   logic [HIDX_W:0]   m_nx1, m_nx;
   logic              m_end;
   logic              j_last;
   logic              csr_wr;

   logic              mul_start, mul_done;
   logic [PROD_W-1:0] mul_a, mul_res;
   logic [63:0]       mul_b;
   logic              div_start, div_done;
   div_res_type       div_res;

   // Configuration register.
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_IDX_TOL);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_TOL) ? DATA_W'(tol_ff) : '0;

   // Absolute differences and their signs.
   assign sign_t = (t_ff < rdb_ff);
   assign diff_t = sign_t ? (rdb_ff - t_ff) : (t_ff - rdb_ff);
   assign sign_h = (rda_ff < rdb_ff);
   assign diff_h = sign_h ? (rdb_ff - rda_ff) : (rda_ff - rdb_ff);
   assign match  = (diff_t <= TIME_W'(tol_ff));

   assign scan_end = ((FILL_W'(i_ff) + 1'b1) == fill_ff);
   assign j_last   = (j_ff == HIDX_W'(ORDER - 1));

   // Next factor index, skipping the coefficient's own point.
   always_comb begin
      m_nx1 = {1'b0, m_ff} + 1'b1;
      m_nx  = m_nx1;
      if (m_nx1[HIDX_W-1:0] == j_ff && m_nx1 < (HIDX_W + 1)'(ORDER)) begin
         m_nx = m_nx1 + 1'b1;
      end
      m_end = (m_nx >= (HIDX_W + 1)'(ORDER));
   end

   // Memory addresses.
   assign addr_a = lpc_wrap(base_ff, j_ff);
   assign addr_b = lpc_wrap(base_ff, (state_ff == ST_CHK_ADDR) ? i_ff : m_ff);
   assign wen    = (state_ff == ST_APPEND);
   assign waddr  = (fill_ff < FILL_W'(ORDER)) ? lpc_wrap(base_ff, fill_ff[HIDX_W-1:0])
                                              : base_ff;

   always_ff @(posedge clock) begin
      rda_ff <= hist_mem[addr_a];
      rdb_ff <= hist_mem[addr_b];
      if (wen) begin
         hist_mem[waddr] <= t_ff;
      end
   end

   // Shared arithmetic units.
   assign mul_a     = (state_ff == ST_DIFF) ? num_ff : den_ff;
   assign mul_b     = (state_ff == ST_DIFF) ? diff_t : diffd_ff;
   assign div_start = (state_ff == ST_DIV_GO);

   lpc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .opa    (mul_a),
      .opb    (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   lpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .neg   (neg_ff),
      .done  (div_done),
      .res   (div_res)
   );

   // Sequencer: next state and handshake.
   always_comb begin
      state_in       = state_ff;
      mul_start      = 1'b0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = (fill_ff == '0) ? ST_DECIDE : ST_CHK_ADDR;
            end
         end
         ST_CHK_ADDR: state_in = ST_CHK_CMP;
         ST_CHK_CMP: begin
            if (match || scan_end) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_CHK_ADDR;
            end
         end
         ST_DECIDE: begin
            state_in = (fill_ff == FILL_W'(ORDER)) ? ST_COEF_INIT : ST_OUT_INV;
         end
         ST_COEF_INIT: state_in = ST_RD;
         ST_RD:        state_in = ST_DIFF;
         ST_DIFF: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_NUM;
         end
         ST_MUL_NUM: begin
            if (mul_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL_DEN;
            end
         end
         ST_MUL_DEN: begin
            if (mul_done) begin
               state_in = m_end ? ST_DIV_GO : ST_RD;
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               state_in = j_last ? ST_APPEND : ST_COEF_INIT;
            end
         end
         ST_OUT_INV: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= '0;
         fill_ff  <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            tol_ff <= pwdata[TOL_W-1:0];
         end
         if (state_ff == ST_CHK_CMP && match) begin
            fill_ff <= '0;
         end else if (state_ff == ST_APPEND) begin
            if (fill_ff < FILL_W'(ORDER)) begin
               fill_ff <= fill_ff + 1'b1;
            end else begin
               base_ff <= lpc_wrap(base_ff, HIDX_W'(1));
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            t_ff        <= req_chan.sample_time;
            rst_flag_ff <= 1'b0;
            i_ff        <= '0;
            j_ff        <= '0;
         end
         ST_CHK_CMP: begin
            if (match) begin
               rst_flag_ff <= 1'b1;
            end
            i_ff <= i_ff + 1'b1;
         end
         ST_COEF_INIT: begin
            num_ff <= PROD_W'(1) << LIMB_W;
            den_ff <= PROD_W'(1);
            neg_ff <= 1'b0;
            m_ff   <= (j_ff == '0) ? HIDX_W'(1) : '0;
         end
         ST_DIFF: begin
            diffd_ff <= diff_h;
            neg_ff   <= neg_ff ^ sign_t ^ sign_h;
         end
         ST_MUL_NUM: begin
            if (mul_done) begin
               num_ff <= mul_res;
            end
         end
         ST_MUL_DEN: begin
            if (mul_done) begin
               den_ff <= mul_res;
               m_ff   <= m_nx[HIDX_W-1:0];
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               coef_ff <= div_res;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result beat fields.
   assign rsp_chan.coeff_index   = (state_ff == ST_OUT) ? IDX_W'(j_ff) : '0;
   assign rsp_chan.coefficient   = (state_ff == ST_OUT) ? coef_ff.coef : '0;
   assign rsp_chan.coeffs_valid  = (state_ff == ST_OUT);
   assign rsp_chan.history_reset = (state_ff == ST_OUT_INV) && rst_flag_ff;
   assign rsp_chan.saturated     = (state_ff == ST_OUT) && coef_ff.sat;
   assign rsp_chan.last_result   = (state_ff == ST_OUT_INV) || j_last;

endmodule

@@ hw/rtl/lpc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the Lagrange predictor coefficient block.
// Depends on lpc_pkg; bound to the top level at the end of this file.
module lpc_checker import lpc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [IDX_W-1:0]         rsp_coeff_index,
   input logic signed [COEF_W-1:0] rsp_coefficient,
   input logic                     rsp_coeffs_valid,
   input logic                     rsp_history_reset,
   input logic                     rsp_saturated,
   input logic                     rsp_last_result
);

   // One beat at a time: an accepted beat closes the input side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a beat was in progress");

   // The input side stays closed while results are pending.
   a_no_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result beat is pending");

   // A stalled result beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_coefficient)
                                     && $stable(rsp_coeff_index)))
      else $error("result beat changed under stall");

   // Computed coefficients never come with a history reset.
   a_valid_no_reset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coeffs_valid) |-> !rsp_history_reset)
      else $error("history reset flagged on a computed coefficient");

   // An invalid result is a lone, empty final beat.
   a_invalid_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_coeffs_valid) |-> (rsp_last_result && rsp_coeff_index == '0
                                            && rsp_coefficient == '0 && !rsp_saturated))
      else $error("malformed invalid result beat");

endmodule

bind lagrange_predictor_coefficients lpc_checker u_lpc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_coeff_index   (rsp_chan.coeff_index),
   .rsp_coefficient   (rsp_chan.coefficient),
   .rsp_coeffs_valid  (rsp_chan.coeffs_valid),
   .rsp_history_reset (rsp_chan.history_reset),
   .rsp_saturated     (rsp_chan.saturated),
   .rsp_last_result   (rsp_chan.last_result)
);
